/* rtl/core/fic_pkg.sv */
// Package: command codes and shared constants of the float/integer converter.
package fic_pkg;
    localparam logic [2:0] CMD_F32_I32 = 3'd0;
    localparam logic [2:0] CMD_F32_U32 = 3'd1;
    localparam logic [2:0] CMD_F64_I32 = 3'd2;
    localparam logic [2:0] CMD_F64_U32 = 3'd3;
    localparam logic [2:0] CMD_I32_F32 = 3'd4;
    localparam logic [2:0] CMD_U32_F32 = 3'd5;

    localparam logic [31:0] SIGN32         = 32'h8000_0000;
    localparam logic [31:0] I32_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] U32_MAX        = 32'hffff_ffff;
    localparam logic [31:0] MIN_INT_AS_F32 = 32'hcf00_0000;
endpackage

/* rtl/core/float_integer_converter_top.sv */
// Top level of the float/integer converter.
//   channel | signals                      | dir
//   command | i_start, i_command, i_operand | in (busy is out)
//   result  | o_valid, o_result           | out
// One beat per cycle: accepted into an input register, then converted into an output register.
// The busy output is always low.
// Synchronous active-low reset clears the valid flags.
// The receiver cannot stall; each result shows for exactly one cycle.
module float_integer_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_operand,
    output logic        o_valid,
    output logic [31:0] o_result
);
    logic        r_in_vld, r_out_vld;
    logic [2:0]  r_cmd;
    logic [63:0] r_op;
    logic [31:0] r_res, n_res, w_f2i, w_i2f;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= i_command;
        r_op  <= i_operand;
        r_res <= n_res;
    end

    fic_f2i u_f2i (.i_cmd(r_cmd), .i_op(r_op), .o_res(w_f2i));
    fic_i2f u_i2f (.i_signed(r_cmd == fic_pkg::CMD_I32_F32), .i_val(r_op[31:0]),
                   .o_res(w_i2f));

    always_comb begin
        unique case (r_cmd)
            fic_pkg::CMD_F32_I32, fic_pkg::CMD_F32_U32,
            fic_pkg::CMD_F64_I32, fic_pkg::CMD_F64_U32: n_res = w_f2i;
            fic_pkg::CMD_I32_F32, fic_pkg::CMD_U32_F32: n_res = w_i2f;
            default:                                    n_res = '0;
        endcase
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_res;

    a_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_valid) else $error("result beat lost");
    a_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> !o_valid) else $error("result beat invented");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_cmd == fic_pkg::CMD_F32_I32 && r_op[30:23] == 8'hff && r_op[22:0] != 0)
        |=> o_result == 32'd0) else $error("NaN not zeroed");
endmodule

/* rtl/core/fic_f2i.sv */
// Float-to-integer conversion: truncate, saturate, NaN to zero.
module fic_f2i (
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_op,
    output logic [31:0] o_res
);
    logic        w_dbl, w_uns, w_sign, w_nan, w_inf, w_zero;
    logic [10:0] w_ef;
    logic        w_emax, w_fr_nz;
    logic [12:0] w_e;       // signed unbiased exponent
    logic [52:0] w_sig;     // significand aligned to 52 fraction bits
    logic [5:0]  w_sh;
    logic [52:0] w_shr;
    logic [31:0] w_mag;

    always_comb begin
        w_dbl  = (i_cmd == fic_pkg::CMD_F64_I32) || (i_cmd == fic_pkg::CMD_F64_U32);
        w_uns  = (i_cmd == fic_pkg::CMD_F32_U32) || (i_cmd == fic_pkg::CMD_F64_U32);
        if (w_dbl) begin
            w_sign  = i_op[63];
            w_ef    = i_op[62:52];
            w_emax  = (i_op[62:52] == 11'h7ff);
            w_fr_nz = |i_op[51:0];
            w_e     = {2'b00, i_op[62:52]} - 13'd1023;
            w_sig   = {1'b1, i_op[51:0]};
        end else begin
            w_sign  = i_op[31];
            w_ef    = {3'b000, i_op[30:23]};
            w_emax  = (i_op[30:23] == 8'hff);
            w_fr_nz = |i_op[22:0];
            w_e     = {5'b00000, i_op[30:23]} - 13'd127;
            w_sig   = {1'b1, i_op[22:0], 29'd0};
        end
        w_nan  = w_emax && w_fr_nz;
        w_inf  = w_emax && !w_fr_nz;
        w_zero = (w_ef == 11'd0);
        // e in 0..31 here when used; shift right by 52-e
        w_sh   = 6'd52 - w_e[5:0];
        w_shr  = w_sig >> w_sh;
        w_mag  = w_shr[31:0];
        priority if (w_nan)                      o_res = '0;
        else if (w_uns && w_sign)                o_res = '0;
        else if (w_inf)                          o_res = w_uns ? fic_pkg::U32_MAX :
                                                 (w_sign ? fic_pkg::SIGN32 : fic_pkg::I32_MAX);
        else if (w_zero || w_e[12])              o_res = '0;
        else if (w_uns)                          o_res = (w_e >= 13'd32) ? fic_pkg::U32_MAX : w_mag;
        else if (w_e >= 13'd31)                  o_res = w_sign ? fic_pkg::SIGN32 : fic_pkg::I32_MAX;
        else                                     o_res = w_sign ? (32'd0 - w_mag) : w_mag;
    end
endmodule

/* rtl/core/fic_i2f.sv */
// Integer-to-binary32 conversion with round to nearest even.
module fic_i2f (
    input  logic        i_signed,
    input  logic [31:0] i_val,
    output logic [31:0] o_res
);
    logic        w_neg;
    logic [31:0] w_mag, w_norm;
    logic [4:0]  w_p;
    logic [23:0] w_kept;
    logic        w_rnd, w_half, w_sticky;
    logic [24:0] w_sum;
    logic [31:0] w_enc;

    always_comb begin
        w_neg = i_signed && i_val[31];
        w_mag = w_neg ? (32'd0 - i_val) : i_val;
        w_p   = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_mag[i]) w_p = 5'(i);
        end
        w_norm   = w_mag << (5'd31 - w_p);
        w_kept   = w_norm[31:8];
        w_half   = w_norm[7];
        w_sticky = |w_norm[6:0];
        w_rnd    = w_half && (w_sticky || w_kept[0]);
        w_sum    = {1'b0, w_kept} + {24'd0, w_rnd};
        // carry into 2^24 bumps the exponent by the add below
        w_enc    = ({24'd0, 3'd0, w_p} + 32'd126 << 23) + {7'd0, w_sum};
        if (i_signed && i_val == fic_pkg::SIGN32) o_res = fic_pkg::MIN_INT_AS_F32;
        else if (w_mag == 32'd0)                  o_res = '0;
        else                                      o_res = {w_neg | w_enc[31], w_enc[30:0]};
    end
endmodule
